// ===== rtl/canonical_huffman_code_builder_top_macros.svh =====
// Assertion macros used by the canonical Huffman code builder top level.
`ifndef CANONICAL_HUFFMAN_CODE_BUILDER_TOP_MACROS_SVH
`define CANONICAL_HUFFMAN_CODE_BUILDER_TOP_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define CHB_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ante.
`define CHB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/chb_pkg.sv =====
// Shared types, constants and helpers of the canonical Huffman code builder.
package chb_pkg;

  localparam int SYM_COUNT     = 256;
  localparam int MAX_CODE_BITS = 32;
  localparam int SYM_W         = $clog2(SYM_COUNT);
  localparam int LEN_W         = 6;
  localparam int CODE_W        = 32;
  localparam int LIDX_W        = $clog2(MAX_CODE_BITS);

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_LOAD   = 2'd1,
    OP_BUILD  = 2'd2,
    OP_LOOKUP = 2'd3
  } op_t;

  // Code store write from the build sweep
  typedef struct packed {
    logic              we;
    logic [SYM_W-1:0]  sym;
    logic [CODE_W-1:0] code;
  } bld_wr_t;

  // Length store read request from the build sweep
  typedef struct packed {
    logic             en;
    logic [SYM_W-1:0] addr;
  } bld_rd_t;

  // Mask covering the low len bits of a code
  function automatic logic [CODE_W-1:0] len_mask(input logic [LEN_W-1:0] len);
    logic [CODE_W-1:0] ones;
    ones = '1;
    if (len == '0) begin
      return '0;
    end else if (len >= LEN_W'(CODE_W)) begin
      return ones;
    end else begin
      return ones >> (LEN_W'(CODE_W) - len);
    end
  endfunction

endpackage

// ===== rtl/chb_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module chb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/chb_builder.sv =====
// Build sequencer: sweeps the length store by length, then symbol, and assigns codes.
module chb_builder (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic                                clear,
  input  logic [chb_pkg::SYM_COUNT-1:0]       present,
  input  logic [chb_pkg::LEN_W-1:0]           len_rdata,
  output logic                                busy,
  output chb_pkg::bld_rd_t                    rd,
  output chb_pkg::bld_wr_t                    wr
);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SWEEP = 3'b010,
    ST_DRAIN = 3'b100
  } state_t;

  state_t                          state;
  state_t                          state_next;
  logic [chb_pkg::SYM_W-1:0]       k;
  logic [chb_pkg::LIDX_W-1:0]      lidx;
  logic                            s1_valid;
  logic [chb_pkg::SYM_W-1:0]       s1_sym;
  logic [chb_pkg::LEN_W-1:0]       s1_len;
  logic                            s1_pres;
  logic [chb_pkg::CODE_W-1:0]      running_code;
  logic [chb_pkg::CODE_W-1:0]      running_code_next;
  logic [chb_pkg::LEN_W-1:0]       cur_len;
  logic [chb_pkg::LEN_W-1:0]       cur_len_next;
  logic [chb_pkg::LEN_W-1:0]       diff;
  logic [chb_pkg::CODE_W-1:0]      shifted;
  logic                            grow;
  logic                            hit;
  logic                            k_last;
  logic                            lidx_last;
  logic [chb_pkg::SYM_W-1:0]       sweep_sym;

  assign busy      = (state != ST_IDLE);
  assign k_last    = (k == chb_pkg::SYM_W'(chb_pkg::SYM_COUNT - 1));
  assign lidx_last = (lidx == chb_pkg::LIDX_W'(chb_pkg::MAX_CODE_BITS - 1));
  // Signed 8-bit order: 128..255 first, then 0..127
  assign sweep_sym = {~k[chb_pkg::SYM_W-1], k[chb_pkg::SYM_W-2:0]};

  // Issue one length read per sweep cycle
  assign rd.en   = (state == ST_SWEEP);
  assign rd.addr = sweep_sym;

  // Compare returned length and hand out the next code
  always_comb begin
    hit  = s1_valid && s1_pres && (len_rdata == s1_len);
    grow = (s1_len > cur_len);
    diff = s1_len - cur_len;
    if (!grow) begin
      shifted = running_code;
    end else if (diff >= chb_pkg::LEN_W'(chb_pkg::CODE_W)) begin
      shifted = '0;
    end else begin
      shifted = running_code << diff;
    end
    running_code_next = running_code;
    cur_len_next      = cur_len;
    if (hit) begin
      running_code_next = shifted + chb_pkg::CODE_W'(1);
      cur_len_next      = grow ? s1_len : cur_len;
    end
    wr.we   = hit;
    wr.sym  = s1_sym;
    wr.code = shifted & chb_pkg::len_mask(s1_len);
  end

  // Sequence the sweep
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start) state_next = ST_SWEEP;
      end
      ST_SWEEP: begin
        if (k_last && lidx_last) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      s1_valid     <= 1'b0;
      running_code <= '0;
      cur_len      <= '0;
      k            <= '0;
      lidx         <= '0;
    end else begin
      state    <= state_next;
      s1_valid <= (state == ST_SWEEP);
      if (start || clear) begin
        running_code <= '0;
        cur_len      <= '0;
        k            <= '0;
        lidx         <= '0;
      end else begin
        running_code <= running_code_next;
        cur_len      <= cur_len_next;
        if (state == ST_SWEEP) begin
          k <= k + chb_pkg::SYM_W'(1);
          if (k_last) lidx <= lidx + chb_pkg::LIDX_W'(1);
        end
      end
    end
  end

  // Carry the symbol under test alongside its length read
  always_ff @(posedge clk) begin
    if (state == ST_SWEEP) begin
      s1_sym  <= sweep_sym;
      s1_len  <= chb_pkg::LEN_W'(lidx) + chb_pkg::LEN_W'(1);
      s1_pres <= present[sweep_sym];
    end
  end

endmodule

// ===== rtl/canonical_huffman_code_builder_top.sv =====
// Top level of the canonical Huffman code builder: marks, stores and lookup path.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+-----------------------------------
//  in      | input     | in_valid / in_ready    | op, symbol, code_length
//  out     | output    | out_valid / out_ready  | found, codeword, codeword_length
//
// A lookup reads the length and code RAM ports into the lookup stage (p1), then its result
// is registered into the output stage; lookups issue one per cycle while no build runs and
// the output is not stalled. The build sweep reads one length RAM entry per cycle.
// Reset (rst, synchronous) clears present and built marks; the stores need no sweep.
// A stalled result holds the lookup stage; in_ready drops while both are full and out_ready is low.
`include "canonical_huffman_code_builder_top_macros.svh"

module canonical_huffman_code_builder_top (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [1:0]                   op,
  input  logic [chb_pkg::SYM_W-1:0]    symbol,
  input  logic [chb_pkg::LEN_W-1:0]    code_length,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         found,
  output logic [chb_pkg::CODE_W-1:0]   codeword,
  output logic [chb_pkg::LEN_W-1:0]    codeword_length
);

  logic [chb_pkg::SYM_COUNT-1:0] present;
  logic [chb_pkg::SYM_COUNT-1:0] built;
  logic                          in_acc;
  logic                          clear_acc;
  logic                          load_acc;
  logic                          build_acc;
  logic                          lookup_acc;
  logic                          bld_busy;
  chb_pkg::bld_rd_t              bld_rd;
  chb_pkg::bld_wr_t              bld_wr;
  logic [chb_pkg::LEN_W-1:0]     len_sat;
  logic                          len_re;
  logic [chb_pkg::SYM_W-1:0]     len_raddr;
  logic [chb_pkg::LEN_W-1:0]     len_rdata;
  logic [chb_pkg::CODE_W-1:0]    code_rdata;
  logic                          p1_valid;
  logic                          p1_built;
  logic                          p1_move;
  chb_pkg::op_t                  op_c;

  // Decode the accepted transaction
  assign op_c       = chb_pkg::op_t'(op);
  assign p1_move    = p1_valid && (!out_valid || out_ready);
  assign in_ready   = !bld_busy && (!p1_valid || p1_move);
  assign in_acc     = in_valid && in_ready;
  assign clear_acc  = in_acc && (op_c == chb_pkg::OP_CLEAR);
  assign load_acc   = in_acc && (op_c == chb_pkg::OP_LOAD);
  assign build_acc  = in_acc && (op_c == chb_pkg::OP_BUILD);
  assign lookup_acc = in_acc && (op_c == chb_pkg::OP_LOOKUP);

  // Saturate loaded lengths to the widest code
  assign len_sat = (code_length > chb_pkg::LEN_W'(chb_pkg::MAX_CODE_BITS)) ?
                   chb_pkg::LEN_W'(chb_pkg::MAX_CODE_BITS) : code_length;

  // Share the length read port between sweep and lookup
  assign len_re    = bld_busy ? bld_rd.en : lookup_acc;
  assign len_raddr = bld_busy ? bld_rd.addr : symbol;

  chb_ram #(
    .WIDTH (chb_pkg::LEN_W),
    .DEPTH (chb_pkg::SYM_COUNT)
  ) u_len_ram (
    .clk   (clk),
    .we    (load_acc),
    .waddr (symbol),
    .wdata (len_sat),
    .re    (len_re),
    .raddr (len_raddr),
    .rdata (len_rdata)
  );

  chb_ram #(
    .WIDTH (chb_pkg::CODE_W),
    .DEPTH (chb_pkg::SYM_COUNT)
  ) u_code_ram (
    .clk   (clk),
    .we    (bld_wr.we),
    .waddr (bld_wr.sym),
    .wdata (bld_wr.code),
    .re    (lookup_acc),
    .raddr (symbol),
    .rdata (code_rdata)
  );

  chb_builder u_builder (
    .clk       (clk),
    .rst       (rst),
    .start     (build_acc),
    .clear     (clear_acc),
    .present   (present),
    .len_rdata (len_rdata),
    .busy      (bld_busy),
    .rd        (bld_rd),
    .wr        (bld_wr)
  );

  // Maintain present and built marks
  always_ff @(posedge clk) begin
    if (rst) begin
      present <= '0;
      built   <= '0;
    end else begin
      if (clear_acc) begin
        present <= '0;
        built   <= '0;
      end else if (build_acc) begin
        built <= '0;
      end else if (load_acc) begin
        present[symbol] <= 1'b1;
        built[symbol]   <= 1'b0;
      end else if (bld_wr.we) begin
        built[bld_wr.sym] <= 1'b1;
      end
    end
  end

  // Track the lookup waiting on RAM data
  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
    end else if (lookup_acc) begin
      p1_valid <= 1'b1;
    end else if (p1_move) begin
      p1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (lookup_acc) begin
      p1_built <= built[symbol];
    end
  end

  // Hold the result until the out transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (p1_move) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (p1_move) begin
      found           <= p1_built;
      codeword        <= p1_built ? (code_rdata & chb_pkg::len_mask(len_rdata)) : '0;
      codeword_length <= p1_built ? len_rdata : '0;
    end
  end

  `CHB_ASSERT_NOW(a_found_has_len, out_valid && found, codeword_length != '0, "found code has zero length")
  `CHB_ASSERT_NOW(a_miss_is_zero, out_valid && !found, (codeword == '0) && (codeword_length == '0), "miss carries nonzero code")
  `CHB_ASSERT_NOW(a_wr_in_build, bld_wr.we, bld_busy || $past(bld_busy), "code write outside build")
  `CHB_ASSERT_NEXT(a_build_starts, build_acc, bld_busy && !p1_valid, "build did not start cleanly")
  `CHB_ASSERT_NEXT(a_stall_holds, p1_valid && !p1_move, p1_valid && $stable(p1_built), "stalled lookup lost")

endmodule
